// ===== rtl/vector_keyframe_reducer_defines.svh =====
// ---------------------------------------------------------------------------
// Keyframe reducer assertion macros
// Shared property forms for the concurrent checks of the keyframe reducer.
// ---------------------------------------------------------------------------
`ifndef VECTOR_KEYFRAME_REDUCER_DEFINES_SVH
`define VECTOR_KEYFRAME_REDUCER_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define VKR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define VKR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vkr_pkg.sv =====
// ---------------------------------------------------------------------------
// Keyframe reducer package
// Register indexes, arithmetic step codes and controller/datapath signals.
// ---------------------------------------------------------------------------
`default_nettype none

package vkr_pkg;

  localparam int THR_BITS = 20;
  localparam int CFG_INDEX_BITS = 1;
  localparam int SCALE_SHIFT = 32;
  localparam logic [THR_BITS-1:0] THR_RESET = 20'd32768;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 1'd1;

  typedef enum logic [4:0] {
    STEP_DD0     = 5'd0,
    STEP_DD1     = 5'd1,
    STEP_DD2     = 5'd2,
    STEP_DE0     = 5'd3,
    STEP_DE1     = 5'd4,
    STEP_DE2     = 5'd5,
    STEP_C0A     = 5'd6,
    STEP_C0B     = 5'd7,
    STEP_C1A     = 5'd8,
    STEP_C1B     = 5'd9,
    STEP_C2A     = 5'd10,
    STEP_C2B     = 5'd11,
    STEP_CC0     = 5'd12,
    STEP_CC1     = 5'd13,
    STEP_CC2     = 5'd14,
    STEP_LEN_THR = 5'd15,
    STEP_LSQ     = 5'd16
  } step_t;

  typedef struct packed {
    logic  load_key;
    logic  mul_start;
    logic  wb;
    logic  load_pend;
    logic  emit_pend;
    logic  emit_key;
    step_t step;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic len2_zero;
    logic all_eq;
    logic t_reject;
    logic cmp_le;
    logic out_free;
    logic key_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/vkr_key_if.sv =====
// ---------------------------------------------------------------------------
// Keyframe input channel
// Valid/ready channel carrying one keyframe per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface vkr_key_if #(
  parameter int COORD_BITS = 24,
  parameter int TIME_BITS  = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] key_x;
  logic signed [COORD_BITS-1:0] key_y;
  logic signed [COORD_BITS-1:0] key_z;
  logic [TIME_BITS-1:0]         key_time;
  logic                         track_end;

  modport source (output valid, key_x, key_y, key_z, key_time, track_end, input ready);
  modport sink (input valid, key_x, key_y, key_z, key_time, track_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/vkr_kept_if.sv =====
// ---------------------------------------------------------------------------
// Kept keyframe output channel
// Valid/ready channel carrying one kept keyframe per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface vkr_kept_if #(
  parameter int COORD_BITS = 24,
  parameter int TIME_BITS  = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] kept_x;
  logic signed [COORD_BITS-1:0] kept_y;
  logic signed [COORD_BITS-1:0] kept_z;
  logic [TIME_BITS-1:0]         kept_time;
  logic                         kept_last;

  modport source (output valid, kept_x, kept_y, kept_z, kept_time, kept_last, input ready);
  modport sink (input valid, kept_x, kept_y, kept_z, kept_time, kept_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/vector_keyframe_reducer.sv =====
// ---------------------------------------------------------------------------
// Vector keyframe reducer
// Keyframes of a track enter one transaction at a time; the first and last
// keys are always kept, and a middle key is dropped when it lies within the
// chord span and its distance to the chord is at most error_threshold/2^16
// times the chord length, decided exactly in wide integer arithmetic. A
// middle key is released only once its successor has arrived. The tests of
// one key run as up to seventeen products through a single multiplier that
// takes sixteen multiplier bits per cycle. Each product is started, run
// through the multiplier digit by digit until done, written back and then
// checked. A key under test holds the input from acceptance until the
// block is ready again. Each emitted result also waits for the output
// register to be free. Configuration is written through cfg_we, cfg_index
// and cfg_data; index 0 is enable_reduction, index 1 is error_threshold.
// The user must write it only while the block is idle; the block itself
// does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none
`include "vector_keyframe_reducer_defines.svh"

module vector_keyframe_reducer #(
  parameter int COORD_BITS = 24,
  parameter int TIME_BITS  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  vkr_key_if.sink                                  key,
  vkr_kept_if.source                               kept,
  input  wire logic                                cfg_we,
  input  wire logic [vkr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [vkr_pkg::THR_BITS-1:0]        cfg_data
);

  logic                         enable_reduction;
  logic [vkr_pkg::THR_BITS-1:0] error_threshold;
  vkr_pkg::dp_cmd_t             dp_cmd;
  vkr_pkg::dp_sts_t             dp_sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_reduction <= 1'b1;
      error_threshold  <= vkr_pkg::THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vkr_pkg::REG_ENABLE:    enable_reduction <= cfg_data[0];
        vkr_pkg::REG_THRESHOLD: error_threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  vkr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (key.valid),
    .in_ready (key.ready),
    .enable   (enable_reduction),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  vkr_dp #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .threshold (error_threshold),
    .in_x      (key.key_x),
    .in_y      (key.key_y),
    .in_z      (key.key_z),
    .in_time   (key.key_time),
    .in_last   (key.track_end),
    .out_valid (kept.valid),
    .out_ready (kept.ready),
    .out_x     (kept.kept_x),
    .out_y     (kept.kept_y),
    .out_z     (kept.kept_z),
    .out_time  (kept.kept_time),
    .out_last  (kept.kept_last)
  );

  `VKR_ASSERT_NEXT(a_accept_then_busy, key.valid && key.ready, !key.ready, "Input taken twice in a row.")
  `VKR_ASSERT_NOW(a_emit_into_free, dp_cmd.emit_pend || dp_cmd.emit_key, !kept.valid || kept.ready, "Result register overwritten.")
  `VKR_ASSERT_NEXT(a_emit_shows, dp_cmd.emit_pend || dp_cmd.emit_key, kept.valid, "Emitted result not presented.")

endmodule

`default_nettype wire

// ===== rtl/vkr_mul.sv =====
// ---------------------------------------------------------------------------
// Keyframe reducer multiplier
// Unsigned multiplier that consumes sixteen multiplier bits per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module vkr_mul #(
  parameter int W = 72
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [W-1:0]   a,
  input  wire logic [W-1:0]   b,
  output logic                done,
  output logic [2*W-1:0]      prod
);

  localparam int DIGW  = 16;
  localparam int NDIG  = (W + DIGW - 1) / DIGW;
  localparam int LOW   = NDIG * DIGW;
  localparam int PRW   = W + LOW;
  localparam int CNT_W = $clog2(NDIG + 1);

  logic [W-1:0]      a_r;
  logic [PRW-1:0]    acc;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [W+DIGW-1:0] pp;
  logic [W+DIGW-1:0] sum;

  assign pp   = a_r * acc[DIGW-1:0];
  assign sum  = pp + (W+DIGW)'(acc[PRW-1:LOW]);
  assign prod = acc[2*W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NDIG - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      acc <= {{W{1'b0}}, LOW'(b)};
    end else if (busy) begin
      acc <= {sum, acc[LOW-1:DIGW]};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vkr_ctrl.sv =====
// ---------------------------------------------------------------------------
// Keyframe reducer controller
// Track phase, arithmetic step sequencing and result emission.
// ---------------------------------------------------------------------------
`default_nettype none

module vkr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            enable,
  input  wire vkr_pkg::dp_sts_t sts,
  output vkr_pkg::dp_cmd_t     cmd
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_LAUNCH    = 6'b000010,
    S_MUL       = 6'b000100,
    S_CHECK     = 6'b001000,
    S_EMIT_PEND = 6'b010000,
    S_KEYDEC    = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    PHASE_NONE    = 2'd0,
    PHASE_ANCHOR  = 2'd1,
    PHASE_PENDING = 2'd2
  } phase_t;

  state_t         state, state_next;
  phase_t         phase, phase_next;
  vkr_pkg::step_t step, step_next;
  logic           emit_key_wait, emit_key_wait_next;
  logic           decided;
  logic           redundant;

  always_comb begin
    state_next         = state;
    phase_next         = phase;
    step_next          = step;
    emit_key_wait_next = emit_key_wait;
    in_ready           = 1'b0;
    cmd                = '0;
    cmd.step           = step;
    decided            = 1'b0;
    redundant          = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !emit_key_wait;
        if (emit_key_wait) begin
          if (sts.out_free) begin
            cmd.emit_key       = 1'b1;
            phase_next         = sts.key_last ? PHASE_NONE : PHASE_ANCHOR;
            emit_key_wait_next = 1'b0;
          end
        end else if (in_valid) begin
          cmd.load_key = 1'b1;
          if (phase == PHASE_PENDING) begin
            if (enable) begin
              step_next  = vkr_pkg::STEP_DD0;
              state_next = S_LAUNCH;
            end else begin
              state_next = S_EMIT_PEND;
            end
          end else begin
            state_next = S_KEYDEC;
          end
        end
      end
      S_LAUNCH: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        if (sts.mul_done) begin
          cmd.wb     = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (step == vkr_pkg::STEP_DD2 && sts.len2_zero) begin
          decided   = 1'b1;
          redundant = sts.all_eq;
        end else if (step == vkr_pkg::STEP_DE2 && sts.t_reject) begin
          decided = 1'b1;
        end else if (step == vkr_pkg::STEP_LSQ) begin
          decided   = 1'b1;
          redundant = sts.cmp_le;
        end else begin
          step_next  = vkr_pkg::step_t'(step + 5'd1);
          state_next = S_LAUNCH;
        end
        if (decided) begin
          if (redundant) begin
            phase_next = PHASE_ANCHOR;
            state_next = S_KEYDEC;
          end else begin
            state_next = S_EMIT_PEND;
          end
        end
      end
      S_EMIT_PEND: begin
        if (sts.out_free) begin
          cmd.emit_pend = 1'b1;
          phase_next    = PHASE_ANCHOR;
          state_next    = S_KEYDEC;
        end
      end
      S_KEYDEC: begin
        state_next = S_IDLE;
        if (phase == PHASE_ANCHOR && enable && !sts.key_last) begin
          cmd.load_pend = 1'b1;
          phase_next    = PHASE_PENDING;
        end else begin
          emit_key_wait_next = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PHASE_NONE;
      step          <= vkr_pkg::STEP_DD0;
      emit_key_wait <= 1'b0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      step          <= step_next;
      emit_key_wait <= emit_key_wait_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vkr_dp.sv =====
// ---------------------------------------------------------------------------
// Keyframe reducer datapath
// Key, anchor and pending registers, exact chord test and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module vkr_dp #(
  parameter int COORD_BITS = 24,
  parameter int TIME_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire vkr_pkg::dp_cmd_t             cmd,
  output vkr_pkg::dp_sts_t                  sts,
  input  wire logic [vkr_pkg::THR_BITS-1:0] threshold,
  input  wire logic signed [COORD_BITS-1:0] in_x,
  input  wire logic signed [COORD_BITS-1:0] in_y,
  input  wire logic signed [COORD_BITS-1:0] in_z,
  input  wire logic [TIME_BITS-1:0]         in_time,
  input  wire logic                         in_last,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [COORD_BITS-1:0]      out_x,
  output logic signed [COORD_BITS-1:0]      out_y,
  output logic signed [COORD_BITS-1:0]      out_z,
  output logic [TIME_BITS-1:0]              out_time,
  output logic                              out_last
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int TW = PW + 1;
  localparam int MW = PW + vkr_pkg::THR_BITS;

  logic signed [COORD_BITS-1:0] key_pt [3];
  logic signed [COORD_BITS-1:0] anc    [3];
  logic signed [COORD_BITS-1:0] pend   [3];
  logic [TIME_BITS-1:0]         key_time;
  logic [TIME_BITS-1:0]         pend_time;
  logic                         key_last;

  logic signed [DW-1:0] d [3];
  logic signed [DW-1:0] e [3];
  logic [DW-1:0]        d_mag [3];
  logic [DW-1:0]        e_mag [3];
  logic signed [TW-1:0] c [3];
  logic [TW-1:0]        c_mag [3];

  logic [PW-1:0]        len2;
  logic signed [TW-1:0] t;
  logic [2*PW-1:0]      cr_sum;
  logic [MW-1:0]        lthr;

  logic [MW-1:0]        op_a;
  logic [MW-1:0]        op_b;
  logic                 op_neg;
  logic                 mul_done;
  logic [2*MW-1:0]      prod;
  logic signed [TW-1:0] sp;

  for (genvar i = 0; i < 3; i++) begin : g_diff
    assign d[i]     = DW'(key_pt[i]) - DW'(anc[i]);
    assign e[i]     = DW'(pend[i]) - DW'(anc[i]);
    assign d_mag[i] = d[i][DW-1] ? DW'(-d[i]) : DW'(d[i]);
    assign e_mag[i] = e[i][DW-1] ? DW'(-e[i]) : DW'(e[i]);
    assign c_mag[i] = c[i][TW-1] ? TW'(-c[i]) : TW'(c[i]);
  end

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_neg = 1'b0;
    unique case (cmd.step)
      vkr_pkg::STEP_DD0: begin op_a = MW'(d_mag[0]); op_b = MW'(d_mag[0]); end
      vkr_pkg::STEP_DD1: begin op_a = MW'(d_mag[1]); op_b = MW'(d_mag[1]); end
      vkr_pkg::STEP_DD2: begin op_a = MW'(d_mag[2]); op_b = MW'(d_mag[2]); end
      vkr_pkg::STEP_DE0: begin
        op_a = MW'(d_mag[0]); op_b = MW'(e_mag[0]); op_neg = d[0][DW-1] ^ e[0][DW-1];
      end
      vkr_pkg::STEP_DE1: begin
        op_a = MW'(d_mag[1]); op_b = MW'(e_mag[1]); op_neg = d[1][DW-1] ^ e[1][DW-1];
      end
      vkr_pkg::STEP_DE2: begin
        op_a = MW'(d_mag[2]); op_b = MW'(e_mag[2]); op_neg = d[2][DW-1] ^ e[2][DW-1];
      end
      vkr_pkg::STEP_C0A: begin
        op_a = MW'(d_mag[1]); op_b = MW'(e_mag[2]); op_neg = d[1][DW-1] ^ e[2][DW-1];
      end
      vkr_pkg::STEP_C0B: begin
        op_a = MW'(d_mag[2]); op_b = MW'(e_mag[1]); op_neg = d[2][DW-1] ^ e[1][DW-1];
      end
      vkr_pkg::STEP_C1A: begin
        op_a = MW'(d_mag[2]); op_b = MW'(e_mag[0]); op_neg = d[2][DW-1] ^ e[0][DW-1];
      end
      vkr_pkg::STEP_C1B: begin
        op_a = MW'(d_mag[0]); op_b = MW'(e_mag[2]); op_neg = d[0][DW-1] ^ e[2][DW-1];
      end
      vkr_pkg::STEP_C2A: begin
        op_a = MW'(d_mag[0]); op_b = MW'(e_mag[1]); op_neg = d[0][DW-1] ^ e[1][DW-1];
      end
      vkr_pkg::STEP_C2B: begin
        op_a = MW'(d_mag[1]); op_b = MW'(e_mag[0]); op_neg = d[1][DW-1] ^ e[0][DW-1];
      end
      vkr_pkg::STEP_CC0: begin op_a = MW'(c_mag[0]); op_b = MW'(c_mag[0]); end
      vkr_pkg::STEP_CC1: begin op_a = MW'(c_mag[1]); op_b = MW'(c_mag[1]); end
      vkr_pkg::STEP_CC2: begin op_a = MW'(c_mag[2]); op_b = MW'(c_mag[2]); end
      vkr_pkg::STEP_LEN_THR: begin op_a = MW'(len2); op_b = MW'(threshold); end
      vkr_pkg::STEP_LSQ: begin op_a = lthr; op_b = lthr; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  vkr_mul #(.W(MW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .prod  (prod)
  );

  assign sp = op_neg ? -$signed(TW'(prod)) : $signed(TW'(prod));

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      case (cmd.step)
        vkr_pkg::STEP_DD0: len2 <= prod[PW-1:0];
        vkr_pkg::STEP_DD1, vkr_pkg::STEP_DD2: len2 <= len2 + prod[PW-1:0];
        vkr_pkg::STEP_DE0: t <= sp;
        vkr_pkg::STEP_DE1, vkr_pkg::STEP_DE2: t <= t + sp;
        vkr_pkg::STEP_C0A: c[0] <= sp;
        vkr_pkg::STEP_C0B: c[0] <= c[0] - sp;
        vkr_pkg::STEP_C1A: c[1] <= sp;
        vkr_pkg::STEP_C1B: c[1] <= c[1] - sp;
        vkr_pkg::STEP_C2A: c[2] <= sp;
        vkr_pkg::STEP_C2B: c[2] <= c[2] - sp;
        vkr_pkg::STEP_CC0: cr_sum <= prod[2*PW-1:0];
        vkr_pkg::STEP_CC1, vkr_pkg::STEP_CC2: cr_sum <= cr_sum + prod[2*PW-1:0];
        vkr_pkg::STEP_LEN_THR: lthr <= prod[MW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_pt[0] <= in_x;
      key_pt[1] <= in_y;
      key_pt[2] <= in_z;
      key_time  <= in_time;
      key_last  <= in_last;
    end
    if (cmd.load_pend) begin
      pend      <= key_pt;
      pend_time <= key_time;
    end
    if (cmd.emit_pend) begin
      anc <= pend;
    end else if (cmd.emit_key) begin
      anc <= key_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pend) begin
      out_x    <= pend[0];
      out_y    <= pend[1];
      out_z    <= pend[2];
      out_time <= pend_time;
      out_last <= 1'b0;
    end else if (cmd.emit_key) begin
      out_x    <= key_pt[0];
      out_y    <= key_pt[1];
      out_z    <= key_pt[2];
      out_time <= key_time;
      out_last <= key_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_pend || cmd.emit_key) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.mul_done  = mul_done;
  assign sts.len2_zero = (len2 == '0);
  assign sts.all_eq    = (pend[0] == anc[0]) && (pend[1] == anc[1]) && (pend[2] == anc[2]);
  assign sts.t_reject  = t[TW-1] || (t > $signed({1'b0, len2}));
  assign sts.cmp_le    = ((2*MW)'(cr_sum) << vkr_pkg::SCALE_SHIFT) <= prod;
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.key_last  = key_last;

endmodule

`default_nettype wire
